### rtl/dsfd_pkg.sv
// Shared types and constants for the serial frame deframer.
// No dependencies; imported by every module of the block.
package dsfd_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned WORD_W    = 16;
    localparam int unsigned CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SECOND = 2'd1;

    // Reset values of the sync bytes
    localparam logic [BYTE_W-1:0] HEADER_FIRST_RST  = 8'h5A;
    localparam logic [BYTE_W-1:0] HEADER_SECOND_RST = 8'hA5;

    // Frames shorter than this miss at least one field
    localparam logic [BYTE_W-1:0] FULL_FRAME_LEN = 8'd6;

    typedef struct packed {
        logic [BYTE_W-1:0] command_code;
        logic [WORD_W-1:0] var_address;
        logic [BYTE_W-1:0] word_count;
        logic [WORD_W-1:0] var_value;
        logic [BYTE_W-1:0] frame_length;
        logic              short_frame;
    } frame_result_t;

endpackage

### rtl/dsfd_parser.sv
// Frame parser: header hunt, length capture and payload field collection.
// Depends on dsfd_pkg.
module dsfd_parser
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic [dsfd_pkg::BYTE_W-1:0]   rx_byte,
    input  logic [dsfd_pkg::BYTE_W-1:0]   header_first,
    input  logic [dsfd_pkg::BYTE_W-1:0]   header_second,
    output logic                          emit,
    output dsfd_pkg::frame_result_t       result
);
    import dsfd_pkg::*;

    localparam logic [1:0] PH_HUNT    = 2'd0;
    localparam logic [1:0] PH_SECOND  = 2'd1;
    localparam logic [1:0] PH_LENGTH  = 2'd2;
    localparam logic [1:0] PH_PAYLOAD = 2'd3;

    logic [1:0]        phase_reg, phase_next;
    logic [BYTE_W-1:0] exp_len_reg, exp_len_next;
    logic [BYTE_W-1:0] count_reg, count_next;
    logic [BYTE_W-1:0] cmd_reg, cmd_next;
    logic [WORD_W-1:0] addr_reg, addr_next;
    logic [BYTE_W-1:0] wcnt_reg, wcnt_next;
    logic [WORD_W-1:0] value_reg, value_next;
    logic [BYTE_W-1:0] count_inc;

    assign count_inc = count_reg + 8'd1;

    always_comb
    begin
        phase_next   = phase_reg;
        exp_len_next = exp_len_reg;
        count_next   = count_reg;
        cmd_next     = cmd_reg;
        addr_next    = addr_reg;
        wcnt_next    = wcnt_reg;
        value_next   = value_reg;
        emit         = 1'b0;
        unique case (phase_reg)
            PH_HUNT:
            begin
                if (rx_byte == header_first)
                    phase_next = PH_SECOND;
            end
            PH_SECOND:
            begin
                priority if (rx_byte == header_second)
                    phase_next = PH_LENGTH;
                else if (rx_byte == header_first)
                    phase_next = PH_SECOND;
                else
                    phase_next = PH_HUNT;
            end
            PH_LENGTH:
            begin
                exp_len_next = rx_byte;
                count_next   = '0;
                cmd_next     = '0;
                addr_next    = '0;
                wcnt_next    = '0;
                value_next   = '0;
                if (rx_byte == '0)
                begin
                    phase_next = PH_HUNT;
                    emit       = 1'b1;
                end
                else
                begin
                    phase_next = PH_PAYLOAD;
                end
            end
            default:
            begin
                unique case (count_reg)
                    8'd0:    cmd_next   = rx_byte;
                    8'd1:    addr_next  = {rx_byte, addr_reg[BYTE_W-1:0]};
                    8'd2:    addr_next  = {addr_reg[WORD_W-1:BYTE_W], rx_byte};
                    8'd3:    wcnt_next  = rx_byte;
                    8'd4:    value_next = {rx_byte, value_reg[BYTE_W-1:0]};
                    8'd5:    value_next = {value_reg[WORD_W-1:BYTE_W], rx_byte};
                    default: ;
                endcase
                count_next = count_inc;
                if (count_inc >= exp_len_reg)
                begin
                    phase_next = PH_HUNT;
                    emit       = 1'b1;
                end
            end
        endcase
    end

    // Result reflects the field values after this byte is absorbed
    assign result.command_code = cmd_next;
    assign result.var_address  = addr_next;
    assign result.word_count   = wcnt_next;
    assign result.var_value    = value_next;
    assign result.frame_length = exp_len_next;
    assign result.short_frame  = (exp_len_next < FULL_FRAME_LEN);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HUNT;
            exp_len_reg <= '0;
            count_reg   <= '0;
            cmd_reg     <= '0;
            addr_reg    <= '0;
            wcnt_reg    <= '0;
            value_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            exp_len_reg <= exp_len_next;
            count_reg   <= count_next;
            cmd_reg     <= cmd_next;
            addr_reg    <= addr_next;
            wcnt_reg    <= wcnt_next;
            value_reg   <= value_next;
        end
    end

`ifndef NO_ASSERTIONS
    // A finished frame always returns to header hunt
    a_emit_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        step && emit |=> phase_reg == PH_HUNT)
        else $error("frame end did not return to hunt");

    // While collecting, the count never reaches the frame length
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAYLOAD |-> count_reg < exp_len_reg)
        else $error("payload count overran frame length");

    // Entering payload collection needs a nonzero length
    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        step && phase_reg == PH_LENGTH && phase_next == PH_PAYLOAD
        |=> exp_len_reg != '0)
        else $error("payload phase with zero length");
`endif

endmodule

### rtl/dsfd_out_stage.sv
// Result register between the parser and the output channel.
// Depends on dsfd_pkg.
module dsfd_out_stage
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     load,
    input  dsfd_pkg::frame_result_t  result_in,
    output logic                     free,
    output logic                     out_valid,
    input  logic                     out_stall,
    output dsfd_pkg::frame_result_t  result_out
);
    import dsfd_pkg::*;

    logic          valid_reg;
    frame_result_t data_reg;

    // Slot can be written when empty or drained this cycle
    assign free       = !valid_reg || !out_stall;
    assign out_valid  = valid_reg;
    assign result_out = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (free)
            valid_reg <= load;
    end

    always_ff @(posedge clk)
    begin
        if (free && load)
            data_reg <= result_in;
    end

endmodule

### rtl/display_serial_frame_deframer.sv
// Top level of the length-prefixed serial frame deframer.
// Depends on dsfd_pkg, dsfd_parser and dsfd_out_stage.
//
// Usage:
//   Input channel: in_valid / in_stall carry one received byte (rx_byte) per
//   transfer. Output channel: out_valid / out_stall carry one decoded frame
//   (command_code, var_address, word_count, var_value, frame_length,
//   short_frame) per transfer, produced when the last payload byte arrives
//   (or on the length byte of a zero-length frame).
//   Config channel: cfg_valid / cfg_ready with cfg_index and cfg_data;
//   index 0 is the first sync byte, index 1 the second, others ignored.
//   cfg_ready is always high. Write only while the block is idle.
// Datapath:
//   A byte lands in an input register, then the parser logic writes the result
//   register, which drives the outputs until the frame transfers out. One byte
//   per cycle is sustained while out_stall does not hold a pending result.
// Reset: sync bytes return to 0x5A / 0xA5, the parser hunts for a header,
//   both registers empty.
// Stall: while out_stall holds a pending result, the byte in the input
//   register waits and in_stall rises; nothing is dropped.
module display_serial_frame_deframer
(
    input  logic                            clk,
    input  logic                            rst_n,
    // byte input
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [dsfd_pkg::BYTE_W-1:0]     rx_byte,
    // frame output
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [dsfd_pkg::BYTE_W-1:0]     command_code,
    output logic [dsfd_pkg::WORD_W-1:0]     var_address,
    output logic [dsfd_pkg::BYTE_W-1:0]     word_count,
    output logic [dsfd_pkg::WORD_W-1:0]     var_value,
    output logic [dsfd_pkg::BYTE_W-1:0]     frame_length,
    output logic                            short_frame,
    // configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [dsfd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dsfd_pkg::BYTE_W-1:0]     cfg_data
);
    import dsfd_pkg::*;

    logic              byte_valid_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic [BYTE_W-1:0] hdr_first_reg;
    logic [BYTE_W-1:0] hdr_second_reg;
    logic              slot_free;
    logic              advance;
    logic              emit;
    frame_result_t     result;
    frame_result_t     result_q;

    // Held byte moves into the parser when the result slot can take it
    assign advance  = byte_valid_reg && slot_free;
    assign in_stall = byte_valid_reg && !slot_free;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            byte_valid_reg <= 1'b0;
        else if (!in_stall)
            byte_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            byte_reg <= rx_byte;
    end

    // Sync byte registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_first_reg  <= HEADER_FIRST_RST;
            hdr_second_reg <= HEADER_SECOND_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_HEADER_FIRST)
                hdr_first_reg <= cfg_data;
            if (cfg_index == CFG_HEADER_SECOND)
                hdr_second_reg <= cfg_data;
        end
    end

    dsfd_parser u_parser
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (advance),
        .rx_byte       (byte_reg),
        .header_first  (hdr_first_reg),
        .header_second (hdr_second_reg),
        .emit          (emit),
        .result        (result)
    );

    dsfd_out_stage u_out
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (advance && emit),
        .result_in  (result),
        .free       (slot_free),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .result_out (result_q)
    );

    assign command_code = result_q.command_code;
    assign var_address  = result_q.var_address;
    assign word_count   = result_q.word_count;
    assign var_value    = result_q.var_value;
    assign frame_length = result_q.frame_length;
    assign short_frame  = result_q.short_frame;

endmodule

### tb/sv/display_serial_frame_deframer_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for display_serial_frame_deframer: byte stream in, decoded frames out.
// Depends on dsfd_pkg and the RTL of the block; checks every frame against a built-in decoder.
module display_serial_frame_deframer_tb;
    import dsfd_pkg::*;

    // Run limits and pacing
    localparam int unsigned DIRECTED_ROWS    = 23;
    localparam int unsigned ITEM_TARGET      = 1850;
    localparam int unsigned SETTLE_CYCLES    = 4;
    localparam int unsigned LONG_HOLD_CYCLES = 150;
    localparam int unsigned WATCHDOG_LIMIT   = 2000;

    // Register indexes past the end of the map; writes to them are dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    typedef enum logic [1:0] {
        SEEK_FIRST,
        SEEK_SECOND,
        TAKE_LENGTH,
        TAKE_PAYLOAD
    } seek_phase_e;

    // One row of the directed stimulus; typed rows carry the frame they must close
    typedef struct packed {
        logic [BYTE_W-1:0] rx;
        logic              typed;
        frame_result_t     frame;
    } stim_row_t;

    // DUT connections; the inputs are known from time zero
    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  in_valid     = 1'b0;
    logic                  in_stall;
    logic [BYTE_W-1:0]     rx_byte      = '0;
    logic                  out_valid;
    logic                  out_stall    = 1'b0;
    logic [BYTE_W-1:0]     command_code;
    logic [WORD_W-1:0]     var_address;
    logic [BYTE_W-1:0]     word_count;
    logic [WORD_W-1:0]     var_value;
    logic [BYTE_W-1:0]     frame_length;
    logic                  short_frame;
    logic                  cfg_valid    = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [BYTE_W-1:0]     cfg_data     = '0;

    // Decoder copy of the block: sync bytes and parse state
    logic [BYTE_W-1:0]     hdr_first    = HEADER_FIRST_RST;
    logic [BYTE_W-1:0]     hdr_second   = HEADER_SECOND_RST;
    seek_phase_e           seek_phase   = SEEK_FIRST;
    logic [BYTE_W-1:0]     want_len     = '0;
    logic [BYTE_W-1:0]     byte_idx     = '0;
    logic [BYTE_W-1:0]     held_cmd     = '0;
    logic [WORD_W-1:0]     held_addr    = '0;
    logic [BYTE_W-1:0]     held_wcount  = '0;
    logic [WORD_W-1:0]     held_val     = '0;

    // Frames decoded from accepted bytes, oldest first
    frame_result_t         pending_frames[$];

    stim_row_t             directed_rows[DIRECTED_ROWS];
    int unsigned           bytes_sent     = 0;
    int unsigned           mismatch_count = 0;
    int unsigned           idle_cycles    = 0;

    // Pacing knobs for the sender and the stall process
    bit                    tx_idle        = 1'b1;
    bit                    rx_idle        = 1'b1;
    bit                    long_hold_req  = 1'b0;
    int unsigned           stall_left     = 0;

    display_serial_frame_deframer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .command_code (command_code),
        .var_address  (var_address),
        .word_count   (word_count),
        .var_value    (var_value),
        .frame_length (frame_length),
        .short_frame  (short_frame),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Gap length: mostly short, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(0, 2);
        else if (r < 95)
            return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    // Decoder: advances the parse state by one byte, returns 1 when a frame closes.
    // Held fields are cleared on the length byte, so fields of a short frame read zero.
    function automatic bit deframe_step(input logic [BYTE_W-1:0] b, output frame_result_t frame);
        bit done;
        done  = 1'b0;
        frame = '0;
        case (seek_phase)
            SEEK_FIRST:
            begin
                if (b == hdr_first)
                    seek_phase = SEEK_SECOND;
            end
            SEEK_SECOND:
            begin
                // a repeated first sync byte restarts the pair, anything else drops back
                if (b == hdr_second)
                    seek_phase = TAKE_LENGTH;
                else if (b == hdr_first)
                    seek_phase = SEEK_SECOND;
                else
                    seek_phase = SEEK_FIRST;
            end
            TAKE_LENGTH:
            begin
                want_len    = b;
                byte_idx    = '0;
                held_cmd    = '0;
                held_addr   = '0;
                held_wcount = '0;
                held_val    = '0;
                if (b == '0)
                begin
                    // empty frame closes on its length byte
                    seek_phase = SEEK_FIRST;
                    done       = 1'b1;
                end
                else
                    seek_phase = TAKE_PAYLOAD;
            end
            default:
            begin
                case (byte_idx)
                    8'd0: held_cmd          = b;
                    8'd1: held_addr[15:8]   = b;
                    8'd2: held_addr[7:0]    = b;
                    8'd3: held_wcount       = b;
                    8'd4: held_val[15:8]    = b;
                    8'd5: held_val[7:0]     = b;
                    default: ;              // trailing payload is counted, not kept
                endcase
                byte_idx = byte_idx + 8'd1;
                if (byte_idx >= want_len)
                begin
                    seek_phase = SEEK_FIRST;
                    done       = 1'b1;
                end
            end
        endcase
        if (done)
            frame = '{held_cmd, held_addr, held_wcount, held_val, want_len,
                      want_len < FULL_FRAME_LEN};
        return done;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic compare_frame(input frame_result_t seen, input frame_result_t want);
        if (seen.command_code !== want.command_code)
            report_mismatch($sformatf("command_code got %h want %h",
                                      seen.command_code, want.command_code));
        if (seen.var_address !== want.var_address)
            report_mismatch($sformatf("var_address got %h want %h",
                                      seen.var_address, want.var_address));
        if (seen.word_count !== want.word_count)
            report_mismatch($sformatf("word_count got %h want %h",
                                      seen.word_count, want.word_count));
        if (seen.var_value !== want.var_value)
            report_mismatch($sformatf("var_value got %h want %h",
                                      seen.var_value, want.var_value));
        if (seen.frame_length !== want.frame_length)
            report_mismatch($sformatf("frame_length got %h want %h",
                                      seen.frame_length, want.frame_length));
        if (seen.short_frame !== want.short_frame)
            report_mismatch($sformatf("short_frame got %b want %b",
                                      seen.short_frame, want.short_frame));
    endtask

    // One byte transfer. Called and returns at a rising edge. Valid stays high
    // across back-to-back transfers; it only drops for a gap.
    task automatic send_byte(input logic [BYTE_W-1:0] b, input bit typed = 1'b0,
                             input frame_result_t typed_frame = '0);
        frame_result_t decoded;
        int unsigned   gap;
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (!(in_valid && !in_stall));
        bytes_sent++;
        if (deframe_step(b, decoded))
            pending_frames.push_back(typed ? typed_frame : decoded);
        else if (typed)
            report_mismatch("directed row closes no frame in the decoder");
        gap = (tx_idle && $urandom_range(0, 99) < 40) ? pick_gap() : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic stop_sending();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Wait until every decoded frame has come out, then let the input register empty
    task automatic drain_frames();
        while (pending_frames.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        if (idx == CFG_HEADER_FIRST)
            hdr_first = data;
        else if (idx == CFG_HEADER_SECOND)
            hdr_second = data;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Mostly well-formed frames with random content; some noise, retries and
    // frames broken after the first sync byte.
    task automatic send_noisy_frame();
        int unsigned r;
        int unsigned len;
        int unsigned noise;
        noise = ($urandom_range(0, 99) < 70) ? 0 : $urandom_range(1, 3);
        repeat (noise) send_byte(BYTE_W'($urandom_range(0, 255)));
        r = $urandom_range(0, 99);
        if (r < 8)
        begin
            // broken pair: first sync byte, then anything
            send_byte(hdr_first);
            send_byte(BYTE_W'($urandom_range(0, 255)));
            return;
        end
        send_byte(hdr_first);
        if (r < 14)
            send_byte(hdr_first);   // repeated first sync byte
        send_byte(hdr_second);
        r = $urandom_range(0, 99);
        if (r < 6)
            len = 0;
        else if (r < 80)
            len = $urandom_range(1, 8);
        else if (r < 98)
            len = $urandom_range(9, 40);
        else
            len = 255;
        send_byte(len[BYTE_W-1:0]);
        repeat (len) send_byte(BYTE_W'($urandom_range(0, 255)));
    endtask

    task automatic run_until(input int unsigned target);
        while (bytes_sent < target)
            send_noisy_frame();
    endtask

    // Output side: stretches of random length, each stalled or not at random (no stall
    // while rx_idle is low), plus one long hold when asked for.
    always @(posedge clk)
    begin
        if (stall_left != 0)
            stall_left--;
        else if (long_hold_req)
        begin
            long_hold_req = 1'b0;
            out_stall    <= 1'b1;
            stall_left    = LONG_HOLD_CYCLES;
        end
        else if (!rx_idle)
            out_stall <= 1'b0;
        else
        begin
            out_stall <= ($urandom_range(0, 2) == 0);
            stall_left = pick_gap();
        end
    end

    // Frame checker: each output transfer against the oldest decoded frame
    always @(posedge clk)
    begin
        frame_result_t seen;
        if (rst_n && out_valid && !out_stall)
        begin
            seen = '{command_code, var_address, word_count, var_value,
                     frame_length, short_frame};
            if (pending_frames.size() == 0)
                report_mismatch($sformatf("unexpected frame cmd %h len %h",
                                          command_code, frame_length));
            else
                compare_frame(seen, pending_frames.pop_front());
        end
    end

    // Watchdog: ends the run after too many cycles with no transfer anywhere
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[%0t] watchdog: no transfer for %0d cycles", $time, idle_cycles);
                $display("display_serial_frame_deframer_tb NOT OK");
                $finish;
            end
        end
    end

    initial
    begin
        // Directed rows under the reset sync bytes 5A / A5
        directed_rows = '{
            // empty frame: closes on the length byte, all fields zero
            '{8'h5A, 1'b0, '0},
            '{8'hA5, 1'b0, '0},
            '{8'h00, 1'b1, '{8'h00, 16'h0000, 8'h00, 16'h0000, 8'h00, 1'b1}},
            // repeated first sync byte, then a 3-byte short frame
            '{8'h5A, 1'b0, '0},
            '{8'h5A, 1'b0, '0},
            '{8'hA5, 1'b0, '0},
            '{8'h03, 1'b0, '0},
            '{8'hFF, 1'b0, '0},
            '{8'h01, 1'b0, '0},
            '{8'h80, 1'b1, '{8'hFF, 16'h0180, 8'h00, 16'h0000, 8'h03, 1'b1}},
            // wrong second sync byte drops back to hunting; A5 alone is ignored
            '{8'h5A, 1'b0, '0},
            '{8'h3C, 1'b0, '0},
            '{8'hA5, 1'b0, '0},
            // full frame with one trailing byte that is discarded
            '{8'h5A, 1'b0, '0},
            '{8'hA5, 1'b0, '0},
            '{8'h07, 1'b0, '0},
            '{8'hFF, 1'b0, '0},
            '{8'hFF, 1'b0, '0},
            '{8'h00, 1'b0, '0},
            '{8'hFF, 1'b0, '0},
            '{8'h00, 1'b0, '0},
            '{8'hFF, 1'b0, '0},
            '{8'h12, 1'b1, '{8'hFF, 16'hFF00, 8'hFF, 16'h00FF, 8'h07, 1'b0}}
        };

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_byte(directed_rows[i].rx, directed_rows[i].typed, directed_rows[i].frame);

        // Reset sync bytes, random pacing on both sides
        run_until(330);

        // Extremes 00 / FF, no idling anywhere
        stop_sending();
        drain_frames();
        cfg_write(CFG_HEADER_FIRST, 8'h00);
        cfg_write(CFG_HEADER_SECOND, 8'hFF);
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        run_until(640);

        // Extremes FF / 00; long receiver hold while bytes keep coming,
        // so the result register fills and the input stalls
        stop_sending();
        drain_frames();
        cfg_write(CFG_HEADER_FIRST, 8'hFF);
        cfg_write(CFG_HEADER_SECOND, 8'h00);
        rx_idle       = 1'b1;
        long_hold_req = 1'b1;
        run_until(950);

        // Equal sync bytes; writes past the register map must change nothing
        stop_sending();
        drain_frames();
        cfg_write(CFG_HEADER_FIRST, 8'h77);
        cfg_write(CFG_HEADER_SECOND, 8'h77);
        cfg_write(CFG_SPARE_2, 8'h00);
        cfg_write(CFG_SPARE_3, 8'hFF);
        tx_idle = 1'b1;
        run_until(1250);

        // Random sync bytes; sender pauses midway until every frame is out
        stop_sending();
        drain_frames();
        cfg_write(CFG_HEADER_FIRST, BYTE_W'($urandom_range(0, 255)));
        cfg_write(CFG_HEADER_SECOND, BYTE_W'($urandom_range(0, 255)));
        run_until(1400);
        stop_sending();
        drain_frames();
        run_until(1550);

        // Back to the reset values
        stop_sending();
        drain_frames();
        cfg_write(CFG_HEADER_FIRST, HEADER_FIRST_RST);
        cfg_write(CFG_HEADER_SECOND, HEADER_SECOND_RST);
        run_until(ITEM_TARGET);

        // Everything offered; wait out the last frames and any stray output
        stop_sending();
        drain_frames();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("display_serial_frame_deframer_tb OK");
        else
            $display("display_serial_frame_deframer_tb NOT OK");
        $finish;
    end

endmodule

### display_serial_frame_deframer.f
rtl/dsfd_pkg.sv
rtl/dsfd_parser.sv
rtl/dsfd_out_stage.sv
rtl/display_serial_frame_deframer.sv
tb/sv/display_serial_frame_deframer_tb.sv
